@@ sv/clock_set_button_controller_core_macros.svh @@
// Assertion macros for the clock-set button controller.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef CLOCK_SET_BUTTON_CONTROLLER_CORE_MACROS_SVH
`define CLOCK_SET_BUTTON_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CSBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CSBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/csbc_pkg.sv @@
// Shared types and constants for the clock-set button controller.
// No dependencies; imported by the interfaces and all modules.
package csbc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_YEAR_FIRST   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_YEAR_LAST    = 2'd3;

    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_MONTH  = 3'd3;
    localparam logic [2:0] FIELD_YEAR   = 3'd4;
    localparam logic [2:0] FIELD_SAVE   = 3'd5;

    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam logic [5:0]  MINUTE_LAST = 6'd59;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;
    localparam logic [4:0]  DAY_LAST    = 5'd31;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;

    localparam logic [15:0] HOLD_TICKS_RST   = 16'd2000;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
    localparam logic [11:0] YEAR_FIRST_RST   = 12'd2024;
    localparam logic [11:0] YEAR_LAST_RST    = 12'd2035;

    typedef struct packed {
        logic        left_button;
        logic        right_button;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [4:0]  now_day;
        logic [3:0]  now_month;
        logic [11:0] now_year;
    } t_in_item;

    typedef struct packed {
        logic        in_set_mode;
        logic [2:0]  selected_field;
        logic [4:0]  edit_hour;
        logic [5:0]  edit_minute;
        logic [4:0]  edit_day;
        logic [3:0]  edit_month;
        logic [11:0] edit_year;
        logic        save_strobe;
    } t_out_item;

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [15:0] idle_timeout_ticks;
        logic [11:0] year_first;
        logic [11:0] year_last;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [2:0]  field_sel;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic        holding;
        logic [15:0] hold_elapsed;
        logic [16:0] idle_elapsed;
        logic        prev_left;
        logic        prev_right;
    } t_state;

    localparam t_state STATE_RST = '{
        mode:         1'b0,
        field_sel:    FIELD_HOUR,
        hour:         5'd0,
        minute:       6'd0,
        day:          DAY_FIRST,
        month:        MONTH_FIRST,
        year:         YEAR_FIRST_RST,
        holding:      1'b0,
        hold_elapsed: 16'd0,
        idle_elapsed: 17'd0,
        prev_left:    1'b1,
        prev_right:   1'b1
    };

endpackage

@@ sv/csbc_if.sv @@
// Valid/ready channel interfaces: button/time input, result output, config write.
// Depends on csbc_pkg for payload types.
interface csbc_in_if import csbc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csbc_out_if import csbc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csbc_cfg_if import csbc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/csbc_cfg.sv @@
// Configuration register file: hold time, idle timeout, year bounds.
// Depends on csbc_pkg and csbc_cfg_if.
module csbc_cfg import csbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csbc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks         <= HOLD_TICKS_RST;
            r_cfg.idle_timeout_ticks <= IDLE_TIMEOUT_RST;
            r_cfg.year_first         <= YEAR_FIRST_RST;
            r_cfg.year_last          <= YEAR_LAST_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_HOLD_TICKS:   r_cfg.hold_ticks         <= i_cfg.data;
                CFG_IDLE_TIMEOUT: r_cfg.idle_timeout_ticks <= i_cfg.data;
                CFG_YEAR_FIRST:   r_cfg.year_first         <= i_cfg.data[11:0];
                CFG_YEAR_LAST:    r_cfg.year_last          <= i_cfg.data[11:0];
            endcase
        end
    end

endmodule

@@ sv/csbc_step.sv @@
// Next-state and result logic for one tick of the button controller.
// Purely combinational; depends on csbc_pkg.
module csbc_step import csbc_pkg::*; (
    input  t_state    i_state,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    logic   left_edge;
    logic   right_edge;
    logic   strobe;
    t_state nxt;

    assign left_edge  = i_item.left_button & ~i_state.prev_left;
    assign right_edge = i_item.right_button & ~i_state.prev_right;

    always_comb begin
        nxt    = i_state;
        strobe = 1'b0;
        if (!i_state.mode) begin
            if (i_item.left_button | i_item.right_button) begin
                if (!i_state.holding) begin
                    nxt.holding      = 1'b1;
                    nxt.hold_elapsed = '0;
                end else if (i_state.hold_elapsed != '1) begin
                    nxt.hold_elapsed = i_state.hold_elapsed + 16'd1;
                end
                if (nxt.hold_elapsed >= i_cfg.hold_ticks) begin
                    nxt.hour         = i_item.now_hour;
                    nxt.minute       = i_item.now_minute;
                    nxt.day          = i_item.now_day;
                    nxt.month        = i_item.now_month;
                    nxt.year         = i_item.now_year;
                    nxt.field_sel    = FIELD_HOUR;
                    nxt.idle_elapsed = '0;
                    nxt.holding      = 1'b0;
                    nxt.hold_elapsed = '0;
                    nxt.prev_left    = 1'b1;
                    nxt.prev_right   = 1'b1;
                    nxt.mode         = 1'b1;
                end
            end else begin
                nxt.holding      = 1'b0;
                nxt.hold_elapsed = '0;
            end
        end else begin
            if (left_edge) begin
                if (i_state.field_sel == FIELD_SAVE) begin
                    strobe   = 1'b1;
                    nxt.mode = 1'b0;
                end else begin
                    unique case (i_state.field_sel)
                        FIELD_HOUR:
                            nxt.hour = (i_state.hour >= HOUR_LAST) ? 5'd0
                                       : i_state.hour + 5'd1;
                        FIELD_MINUTE:
                            nxt.minute = (i_state.minute >= MINUTE_LAST) ? 6'd0
                                         : i_state.minute + 6'd1;
                        FIELD_DAY:
                            nxt.day = (i_state.day >= DAY_LAST) ? DAY_FIRST
                                      : i_state.day + 5'd1;
                        FIELD_MONTH:
                            nxt.month = (i_state.month >= MONTH_LAST) ? MONTH_FIRST
                                        : i_state.month + 4'd1;
                        FIELD_YEAR:
                            nxt.year = (i_state.year >= i_cfg.year_last) ? i_cfg.year_first
                                       : i_state.year + 12'd1;
                        default: ;
                    endcase
                end
            end
            if (right_edge) begin
                nxt.field_sel = (i_state.field_sel >= FIELD_SAVE) ? FIELD_HOUR
                                : i_state.field_sel + 3'd1;
            end
            if (left_edge | right_edge) begin
                nxt.idle_elapsed = '0;
            end else if (i_state.idle_elapsed != '1) begin
                nxt.idle_elapsed = i_state.idle_elapsed + 17'd1;
            end
            if (nxt.idle_elapsed > {1'b0, i_cfg.idle_timeout_ticks}) begin
                nxt.mode = 1'b0;
            end
            nxt.prev_left  = i_item.left_button;
            nxt.prev_right = i_item.right_button;
        end
    end

    assign o_state = nxt;

    assign o_result.in_set_mode    = nxt.mode;
    assign o_result.selected_field = nxt.field_sel;
    assign o_result.edit_hour      = nxt.hour;
    assign o_result.edit_minute    = nxt.minute;
    assign o_result.edit_day       = nxt.day;
    assign o_result.edit_month     = nxt.month;
    assign o_result.edit_year      = nxt.year;
    assign o_result.save_strobe    = strobe;

endmodule

@@ sv/clock_set_button_controller_core.sv @@
// Clock-set button controller, top level.
// Channels: i_in takes one tick beat (two button levels plus current time),
// o_out gives one result beat per input beat (mode, selected field, edit
// registers, save strobe), i_cfg writes the four configuration registers
// (0 hold ticks, 1 idle timeout, 2 first year, 3 last year); always ready.
// Path: an accepted beat is held in the input register, then its tick
// update is stored in the result register, which drives o_out.
// Throughput: one beat per cycle while o_out is taken; the update is a single
// pass of compares and small increments between input and result registers.
// Stall: when o_out is not taken, the result register holds, the input
// register fills, then i_in.ready drops until o_out drains; nothing is lost.
// Reset (i_rst_n low, synchronous): normal mode, hour field, edit time
// 00:00 1/1/2024, counters cleared, config back to defaults, both
// channels empty.
// Depends on csbc_pkg, csbc_if, csbc_cfg, csbc_step and the macro header.
`include "clock_set_button_controller_core_macros.svh"

module clock_set_button_controller_core import csbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csbc_cfg_if.sink    i_cfg,
    csbc_in_if.sink     i_in,
    csbc_out_if.source  o_out
);

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      advance;
    logic      step_fire;

    csbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    csbc_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance    = ~r_out_valid | o_out.ready;
    assign step_fire  = r_in_valid & advance;
    assign i_in.ready = ~r_in_valid | advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RST;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid & i_in.ready) begin
            r_in <= i_in.data;
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    `CSBC_ASSERT_IMPL(a_save_leaves_set, i_clk, i_rst_n, r_out_valid && r_out.save_strobe, !r_out.in_set_mode, "save strobe while still in set mode")
    `CSBC_ASSERT_IMPL(a_field_range, i_clk, i_rst_n, 1'b1, r_state.field_sel <= FIELD_SAVE, "field selector out of range")
    `CSBC_ASSERT_IMPL(a_hold_clear, i_clk, i_rst_n, !r_state.holding, r_state.hold_elapsed == 16'd0, "hold count running without a hold")
    `CSBC_ASSERT_NEXT(a_step_lands, i_clk, i_rst_n, step_fire, r_out_valid, "computed result not registered")
    `CSBC_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in), "stalled input beat dropped")

endmodule

@@ tb/tb_clock_set_button_controller_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for clock_set_button_controller_core: button/time ticks
// in, mode/field/edit-register beats out, checked against an in-bench predictor.
// Depends on csbc_pkg, the csbc_if channel interfaces and the core RTL.
module tb_clock_set_button_controller_core;
    import csbc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic i_clk;
    logic i_rst_n;

    csbc_cfg_if cfg_ch ();
    csbc_in_if  in_ch ();
    csbc_out_if out_ch ();

    clock_set_button_controller_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_state    model_st;
    t_cfg      model_cfg;
    t_out_item view_q[$];

    int n_fail;
    int tick_cnt;
    int cfg_writes;
    int n_entries;
    int n_saves;
    int n_timeouts;
    int cycle_cnt;
    int drain_hold;
    bit tx_burst;
    bit rx_burst;
    bit no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predicted view of the controller after one tick
    function automatic t_out_item next_view(input t_in_item t);
        t_out_item v;
        logic      l_edge;
        logic      r_edge;
        v.save_strobe = 1'b0;
        if (!model_st.mode) begin
            if (t.left_button || t.right_button) begin
                if (!model_st.holding) begin
                    model_st.holding      = 1'b1;
                    model_st.hold_elapsed = '0;
                end else if (model_st.hold_elapsed != 16'hFFFF) begin
                    model_st.hold_elapsed = model_st.hold_elapsed + 16'd1;
                end
                if (model_st.hold_elapsed >= model_cfg.hold_ticks) begin
                    model_st.hour         = t.now_hour;
                    model_st.minute       = t.now_minute;
                    model_st.day          = t.now_day;
                    model_st.month        = t.now_month;
                    model_st.year         = t.now_year;
                    model_st.field_sel    = FIELD_HOUR;
                    model_st.idle_elapsed = '0;
                    model_st.holding      = 1'b0;
                    model_st.hold_elapsed = '0;
                    model_st.prev_left    = 1'b1;
                    model_st.prev_right   = 1'b1;
                    model_st.mode         = 1'b1;
                    n_entries++;
                end
            end else begin
                model_st.holding      = 1'b0;
                model_st.hold_elapsed = '0;
            end
        end else begin
            l_edge = t.left_button && !model_st.prev_left;
            r_edge = t.right_button && !model_st.prev_right;
            if (l_edge) begin
                case (model_st.field_sel)
                    FIELD_HOUR:   model_st.hour =
                        (model_st.hour >= HOUR_LAST) ? 5'd0 : model_st.hour + 5'd1;
                    FIELD_MINUTE: model_st.minute =
                        (model_st.minute >= MINUTE_LAST) ? 6'd0 : model_st.minute + 6'd1;
                    FIELD_DAY:    model_st.day =
                        (model_st.day >= DAY_LAST) ? DAY_FIRST : model_st.day + 5'd1;
                    FIELD_MONTH:  model_st.month =
                        (model_st.month >= MONTH_LAST) ? MONTH_FIRST : model_st.month + 4'd1;
                    FIELD_YEAR:   model_st.year =
                        (model_st.year >= model_cfg.year_last) ? model_cfg.year_first
                                                               : model_st.year + 12'd1;
                    FIELD_SAVE: begin
                        v.save_strobe = 1'b1;
                        model_st.mode = 1'b0;
                        n_saves++;
                    end
                    default: ;
                endcase
            end
            if (r_edge) begin
                model_st.field_sel = (model_st.field_sel >= FIELD_SAVE) ? FIELD_HOUR
                                                                       : model_st.field_sel + 3'd1;
            end
            if (l_edge || r_edge) begin
                model_st.idle_elapsed = '0;
            end else if (model_st.idle_elapsed != 17'h1FFFF) begin
                model_st.idle_elapsed = model_st.idle_elapsed + 17'd1;
            end
            if (model_st.mode && model_st.idle_elapsed > model_cfg.idle_timeout_ticks) begin
                model_st.mode = 1'b0;
                n_timeouts++;
            end
            model_st.prev_left  = t.left_button;
            model_st.prev_right = t.right_button;
        end
        v.in_set_mode    = model_st.mode;
        v.selected_field = model_st.field_sel;
        v.edit_hour      = model_st.hour;
        v.edit_minute    = model_st.minute;
        v.edit_day       = model_st.day;
        v.edit_month     = model_st.month;
        v.edit_year      = model_st.year;
        return v;
    endfunction

    function automatic int pick_wait();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 13);
    endfunction

    function automatic t_in_item make_tick(input logic l, input logic r);
        t_in_item t;
        t.left_button  = l;
        t.right_button = r;
        if ($urandom_range(0, 7) == 0) begin
            t.now_hour   = 5'($urandom);
            t.now_minute = 6'($urandom);
            t.now_day    = 5'($urandom);
            t.now_month  = 4'($urandom);
            t.now_year   = 12'($urandom);
        end else begin
            t.now_hour   = 5'($urandom_range(0, 23));
            t.now_minute = 6'($urandom_range(0, 59));
            t.now_day    = 5'($urandom_range(1, 31));
            t.now_month  = 4'($urandom_range(1, 12));
            t.now_year   = 12'($urandom_range(2000, 2099));
        end
        return t;
    endfunction

    task automatic send_tick(input t_in_item t);
        int gap;
        gap = (no_gaps || tx_burst) ? 0 : pick_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        view_q.push_back(next_view(t));
        tick_cnt++;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    endtask

    task automatic press(input logic l, input logic r);
        send_tick(make_tick(l, r));
    endtask

    task automatic press_any();
        logic [1:0] b;
        b = 2'($urandom_range(1, 3));
        press(b[1], b[0]);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_ch.valid <= 1'b0;
        wait (view_q.size() == 0);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_HOLD_TICKS:   model_cfg.hold_ticks         = val;
            CFG_IDLE_TIMEOUT: model_cfg.idle_timeout_ticks = val;
            CFG_YEAR_FIRST:   model_cfg.year_first         = val[11:0];
            CFG_YEAR_LAST:    model_cfg.year_last          = val[11:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_regs(input int hold, input int idle, input int yf, input int yl);
        write_reg(CFG_HOLD_TICKS, hold[15:0]);
        write_reg(CFG_IDLE_TIMEOUT, idle[15:0]);
        write_reg(CFG_YEAR_FIRST, yf[15:0]);
        write_reg(CFG_YEAR_LAST, yl[15:0]);
        tx_burst = ($urandom_range(0, 3) == 0);
    endtask

    // hold to enter (if hold_ticks < 64), then a run of edits until save, timeout or the action cap
    task automatic run_session();
        int         len;
        int         n;
        logic [1:0] pat;
        len = (model_cfg.hold_ticks < 64) ? int'(model_cfg.hold_ticks) + 1
                                          : $urandom_range(1, 40);
        repeat (len) press_any();
        repeat ($urandom_range(0, 2)) press(1'b0, 1'b0);
        n = 0;
        while (model_st.mode && n < 40) begin
            n++;
            case ($urandom_range(0, 19))
                0: begin
                    if (model_cfg.idle_timeout_ticks < 80) begin
                        repeat (int'(model_cfg.idle_timeout_ticks) + 2) press(1'b0, 1'b0);
                    end
                    pat = 2'b00;
                end
                1:        pat = 2'($urandom);
                2, 3:     pat = 2'b11;
                4, 5, 6, 7, 8, 9, 10: pat = 2'b10;
                default:  pat = 2'b01;
            endcase
            repeat ($urandom_range(1, 3)) press(pat[1], pat[0]);
            repeat ($urandom_range(1, 2)) press(1'b0, 1'b0);
        end
    endtask

    task automatic run_sessions(input int n_ticks);
        int         stop_at;
        logic [1:0] b;
        stop_at = tick_cnt + n_ticks;
        while (tick_cnt < stop_at) begin
            case ($urandom_range(0, 7))
                0: begin
                    repeat ($urandom_range(1, 8)) begin
                        b = 2'($urandom);
                        press(b[1], b[0]);
                    end
                end
                1: begin
                    repeat ($urandom_range(1, 6)) press_any();
                    press(1'b0, 1'b0);
                end
                default: run_session();
            endcase
        end
    endtask

    task automatic test_defaults();
        press(1'b0, 1'b0);
        repeat (3) press(1'b1, 1'b0);
        repeat (2) press(1'b1, 1'b1);
        press(1'b0, 1'b0);
    endtask

    task automatic test_directed_edits();
        t_in_item t;
        set_regs(1, 3, 2024, 2035);
        // all-ones time with day 0: every increment but the day's takes its wrap path; day 0 steps to 1
        t = '1;
        t.right_button = 1'b0;
        t.now_day      = 5'd0;
        send_tick(t);
        send_tick(t);
        press(1'b0, 1'b0);
        repeat (5) begin
            press(1'b1, 1'b0);
            press(1'b0, 1'b1);
        end
        press(1'b0, 1'b0);
        // save and field advance on the same tick
        press(1'b1, 1'b1);
        t = '0;
        t.right_button = 1'b1;
        send_tick(t);
        send_tick(t);
        // button still held after entry gives no edge
        send_tick(t);
        repeat (4) press(1'b0, 1'b0);
    endtask

    task automatic test_long_limits();
        set_regs(65535, 65535, 2000, 2000);
        run_sessions(40);
        set_regs(2, 65535, 2050, 2050);
        run_sessions(150);
    endtask

    task automatic test_idle_extremes();
        set_regs(1, 1, 2098, 2099);
        run_sessions(150);
    endtask

    task automatic test_full_year_span();
        set_regs($urandom_range(1, 6), $urandom_range(4, 30), 2000, 2099);
        run_sessions(250);
    endtask

    task automatic test_year_reversed();
        set_regs($urandom_range(1, 4), $urandom_range(8, 40), 2099, 2000);
        run_sessions(200);
    endtask

    task automatic test_output_stall();
        set_regs($urandom_range(1, 3), $urandom_range(10, 40), 2024, 2035);
        no_gaps    = 1'b1;
        drain_hold = 60;
        run_sessions(80);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (4) begin
            set_regs($urandom_range(1, 12), $urandom_range(2, 60),
                     $urandom_range(2000, 2099), $urandom_range(2000, 2099));
            run_sessions(100);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (view_q.size() == 0) begin
                n_fail++;
                $display("%0t: result beat with nothing expected", $time);
            end else begin
                want = view_q.pop_front();
                check_field("in_set_mode", want.in_set_mode, out_ch.data.in_set_mode);
                check_field("selected_field", want.selected_field, out_ch.data.selected_field);
                check_field("edit_hour", want.edit_hour, out_ch.data.edit_hour);
                check_field("edit_minute", want.edit_minute, out_ch.data.edit_minute);
                check_field("edit_day", want.edit_day, out_ch.data.edit_day);
                check_field("edit_month", want.edit_month, out_ch.data.edit_month);
                check_field("edit_year", want.edit_year, out_ch.data.edit_year);
                check_field("save_strobe", want.save_strobe, out_ch.data.save_strobe);
            end
        end
    end

    // result sink: random stalls, burst stretches, one long hold-off on request
    initial begin
        int stall;
        int n;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (drain_hold > 0) begin
                n          = drain_hold;
                drain_hold = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            stall = rx_burst ? 0 : pick_wait();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("tb_clock_set_button_controller_core NOT OK");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_HOLD_TICKS;
        cfg_ch.data  <= '0;
        model_st     = STATE_RST;
        model_cfg    = '{hold_ticks: HOLD_TICKS_RST, idle_timeout_ticks: IDLE_TIMEOUT_RST,
                         year_first: YEAR_FIRST_RST, year_last: YEAR_LAST_RST};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_directed_edits();
        test_long_limits();
        test_idle_extremes();
        test_full_year_span();
        test_year_reversed();
        test_output_stall();
        test_random_mix();

        in_ch.valid <= 1'b0;
        wait (view_q.size() == 0);
        repeat (8) @(posedge i_clk);

        $display("%0d ticks over %0d register writes, hold/idle/year limits at both ends",
                 tick_cnt, cfg_writes);
        $display("%0d set-mode entries, %0d saves, %0d idle exits",
                 n_entries, n_saves, n_timeouts);
        if (n_fail == 0 && view_q.size() == 0) begin
            $display("tb_clock_set_button_controller_core OK");
        end else begin
            $display("tb_clock_set_button_controller_core NOT OK");
        end
        $finish;
    end
endmodule
